@@ rtl/core/bglt_pkg.sv @@
// Shared types and constants of the bilinear grid table lookup.
`default_nettype none

package bglt_pkg;

    localparam int POS_W      = 24;
    localparam int ENTRY_W    = 24;
    localparam int IDX_W      = 6;
    localparam int HALF_W     = 6;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    // A position sign-extended to this width covers every step up to 2^31.
    localparam int EXT_W      = 32;
    // Signed width of the cell index range checks.
    localparam int CELL_W     = POS_W + 2;
    // The table is split into four banks by column and row parity.
    localparam int NUM_BANKS  = 4;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_HALF_COLS   = 2'd0,
        CFG_HALF_ROWS   = 2'd1,
        CFG_STEP_LOG2   = 2'd2,
        CFG_TABLE_READY = 2'd3
    } cfg_reg_t;

    typedef struct packed
    {
        logic [HALF_W-1:0] half_cols;
        logic [HALF_W-1:0] half_rows;
        logic [STEP_W-1:0] step_log2;
        logic              table_ready;
    } cfg_t;

    // Per-query control that travels beside the table data.
    typedef struct packed
    {
        logic col_odd;
        logic row_odd;
        logic zero;
        logic oor;
    } qctl_t;

endpackage

`default_nettype wire

@@ rtl/core/bglt_locate.sv @@
// Cell location, weights, range check and bank addressing (two pipeline stages).
`default_nettype none

module bglt_locate #(
    parameter int HALF_COLS_MAX = 32,
    parameter int HALF_ROWS_MAX = 32,
    parameter int VALUE_BITS    = 24,
    parameter int WEIGHT_BITS   = 16,
    localparam int COL_HALF_W   = $clog2(HALF_COLS_MAX),
    localparam int ROW_HALF_W   = $clog2(HALF_ROWS_MAX),
    localparam int ADDR_W       = COL_HALF_W + ROW_HALF_W
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire bglt_pkg::cfg_t                          cfg,
    input  wire logic                                    up_valid,
    output logic                                         up_ready,
    input  wire logic                                    cmd,
    input  wire logic [bglt_pkg::IDX_W-1:0]              col,
    input  wire logic [bglt_pkg::IDX_W-1:0]              row,
    input  wire logic [bglt_pkg::ENTRY_W-1:0]            entry_value,
    input  wire logic signed [bglt_pkg::POS_W-1:0]       pos_x,
    input  wire logic signed [bglt_pkg::POS_W-1:0]       pos_y,
    output logic                                         dn_valid,
    input  wire logic                                    dn_ready,
    output logic                                         dn_query,
    output logic [bglt_pkg::NUM_BANKS-1:0]               dn_we,
    output logic [bglt_pkg::NUM_BANKS-1:0][ADDR_W-1:0]   dn_addr,
    output logic [VALUE_BITS-1:0]                        dn_wdata,
    output logic [WEIGHT_BITS-1:0]                       dn_tx,
    output logic [WEIGHT_BITS-1:0]                       dn_ty,
    output bglt_pkg::qctl_t                              dn_ctl
);

    localparam int HCW   = $clog2(HALF_COLS_MAX + 1);
    localparam int HRW   = $clog2(HALF_ROWS_MAX + 1);
    localparam int CXW   = COL_HALF_W + 1;
    localparam int CYW   = ROW_HALF_W + 1;
    localparam int POS_W = bglt_pkg::POS_W;
    localparam int EXT_W = bglt_pkg::EXT_W;
    localparam int CELL_W = bglt_pkg::CELL_W;
    localparam logic signed [CELL_W-1:0] ONE_S = 1;

    // Fraction of the position inside its cell: the low s bits of the
    // sign-extended position.
    function automatic logic [EXT_W-1:0] frac_of(
        input logic signed [POS_W-1:0]       pos,
        input logic [bglt_pkg::STEP_W-1:0]   s
    );
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] mask;
        ext  = {{(EXT_W - POS_W){pos[POS_W-1]}}, pos};
        mask = ~({EXT_W{1'b1}} << s);
        return ext & mask;
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] weight_of(
        input logic [EXT_W-1:0]              frac,
        input logic [bglt_pkg::STEP_W-1:0]   s
    );
        logic [EXT_W+WEIGHT_BITS-1:0] wide;
        wide = {frac, {WEIGHT_BITS{1'b0}}} >> s;
        return wide[WEIGHT_BITS-1:0];
    endfunction

    // Stage A: floor the position to a cell and derive the weights.
    logic                           a_valid_reg;
    logic                           a_ready;
    logic                           a_query_reg;
    logic [bglt_pkg::IDX_W-1:0]     a_col_reg;
    logic [bglt_pkg::IDX_W-1:0]     a_row_reg;
    logic [VALUE_BITS-1:0]          a_entry_reg;
    logic signed [POS_W-1:0]        a_ilx_reg;
    logic signed [POS_W-1:0]        a_ily_reg;
    logic [WEIGHT_BITS-1:0]         a_tx_reg;
    logic [WEIGHT_BITS-1:0]         a_ty_reg;
    logic signed [POS_W-1:0]        a_ilx_next;
    logic signed [POS_W-1:0]        a_ily_next;
    logic [WEIGHT_BITS-1:0]         a_tx_next;
    logic [WEIGHT_BITS-1:0]         a_ty_next;

    // Stage B: range check and bank addresses.
    logic                                       b_valid_reg;
    logic                                       b_ready;
    logic                                       b_query_reg;
    logic [bglt_pkg::NUM_BANKS-1:0]             b_we_reg;
    logic [bglt_pkg::NUM_BANKS-1:0][ADDR_W-1:0] b_addr_reg;
    logic [VALUE_BITS-1:0]                      b_wdata_reg;
    logic [WEIGHT_BITS-1:0]                     b_tx_reg;
    logic [WEIGHT_BITS-1:0]                     b_ty_reg;
    bglt_pkg::qctl_t                            b_ctl_reg;
    logic [bglt_pkg::NUM_BANKS-1:0]             b_we_next;
    logic [bglt_pkg::NUM_BANKS-1:0][ADDR_W-1:0] b_addr_next;
    bglt_pkg::qctl_t                            b_ctl_next;

    logic [HCW-1:0]             hc;
    logic [HRW-1:0]             hr;
    logic signed [CELL_W-1:0]   ilx_w;
    logic signed [CELL_W-1:0]   ily_w;
    logic signed [CELL_W-1:0]   hc_w;
    logic signed [CELL_W-1:0]   hr_w;
    logic signed [CELL_W-1:0]   cx_full;
    logic signed [CELL_W-1:0]   cy_full;
    logic [CXW-1:0]             cx;
    logic [CXW-1:0]             cx1;
    logic [CYW-1:0]             cy;
    logic [CYW-1:0]             cy1;
    logic                       oor_any;
    logic                       wr_ok;
    logic [COL_HALF_W-1:0]      wcol_half;
    logic [ROW_HALF_W-1:0]      wrow_half;
    logic [bglt_pkg::NUM_BANKS-1:0] wbank_hit;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || dn_ready;
    assign up_ready = a_ready;

    always_comb
    begin
        a_ilx_next = pos_x >>> cfg.step_log2;
        a_ily_next = pos_y >>> cfg.step_log2;
        a_tx_next  = weight_of(frac_of(pos_x, cfg.step_log2), cfg.step_log2);
        a_ty_next  = weight_of(frac_of(pos_y, cfg.step_log2), cfg.step_log2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_query_reg <= (cmd == bglt_pkg::CMD_QUERY);
            a_col_reg   <= col;
            a_row_reg   <= row;
            a_entry_reg <= VALUE_BITS'(entry_value);
            a_ilx_reg   <= a_ilx_next;
            a_ily_reg   <= a_ily_next;
            a_tx_reg    <= a_tx_next;
            a_ty_reg    <= a_ty_next;
        end
    end

    always_comb
    begin
        // Grid sizes above the store's capacity saturate.
        hc = (32'(cfg.half_cols) > 32'(HALF_COLS_MAX)) ? HCW'(HALF_COLS_MAX)
                                                       : HCW'(cfg.half_cols);
        hr = (32'(cfg.half_rows) > 32'(HALF_ROWS_MAX)) ? HRW'(HALF_ROWS_MAX)
                                                       : HRW'(cfg.half_rows);
        ilx_w = CELL_W'(a_ilx_reg);
        ily_w = CELL_W'(a_ily_reg);
        hc_w  = $signed(CELL_W'(hc));
        hr_w  = $signed(CELL_W'(hr));
        oor_any = (ilx_w < -hc_w) || (ilx_w + ONE_S >= hc_w)
               || (ily_w < -hr_w) || (ily_w + ONE_S >= hr_w);

        cx_full = ilx_w + hc_w;
        cy_full = ily_w + hr_w;
        cx  = cx_full[CXW-1:0];
        cy  = cy_full[CYW-1:0];
        cx1 = cx + CXW'(1);
        cy1 = cy + CYW'(1);

        wr_ok = (32'(a_col_reg) < 2 * HALF_COLS_MAX) && (32'(a_row_reg) < 2 * HALF_ROWS_MAX);
        wcol_half = COL_HALF_W'(a_col_reg[bglt_pkg::IDX_W-1:1]);
        wrow_half = ROW_HALF_W'(a_row_reg[bglt_pkg::IDX_W-1:1]);

        // Bank index is {row parity, column parity}. Of the two columns cx and
        // cx+1, the even one sits at half index (cx+1)/2 and the odd one at cx/2.
        for (int b = 0; b < bglt_pkg::NUM_BANKS; b++)
        begin
            wbank_hit[b] = (a_col_reg[0] == b[0]) && (a_row_reg[0] == b[1]);
            b_we_next[b] = !a_query_reg && wr_ok && wbank_hit[b];
            if (a_query_reg)
            begin
                b_addr_next[b] = {(b[0] ? cx[CXW-1:1] : cx1[CXW-1:1]),
                                  (b[1] ? cy[CYW-1:1] : cy1[CYW-1:1])};
            end
            else
            begin
                b_addr_next[b] = {wcol_half, wrow_half};
            end
        end

        b_ctl_next.col_odd = cx[0];
        b_ctl_next.row_odd = cy[0];
        b_ctl_next.zero    = !cfg.table_ready || oor_any;
        b_ctl_next.oor     = cfg.table_ready && oor_any;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_query_reg <= a_query_reg;
            b_we_reg    <= b_we_next;
            b_addr_reg  <= b_addr_next;
            b_wdata_reg <= a_entry_reg;
            b_tx_reg    <= a_tx_reg;
            b_ty_reg    <= a_ty_reg;
            b_ctl_reg   <= b_ctl_next;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_query = b_query_reg;
    assign dn_we    = b_we_reg;
    assign dn_addr  = b_addr_reg;
    assign dn_wdata = b_wdata_reg;
    assign dn_tx    = b_tx_reg;
    assign dn_ty    = b_ty_reg;
    assign dn_ctl   = b_ctl_reg;

endmodule

`default_nettype wire

@@ rtl/core/bglt_store.sv @@
// Four-bank grid table: one write or one read per bank and cycle unless the output stalls, read data registered.
`default_nettype none

module bglt_store #(
    parameter int VALUE_BITS  = 24,
    parameter int WEIGHT_BITS = 16,
    parameter int ADDR_W      = 10
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        up_valid,
    output logic                                             up_ready,
    input  wire logic                                        up_query,
    input  wire logic [bglt_pkg::NUM_BANKS-1:0]              up_we,
    input  wire logic [bglt_pkg::NUM_BANKS-1:0][ADDR_W-1:0]  up_addr,
    input  wire logic [VALUE_BITS-1:0]                       up_wdata,
    input  wire logic [WEIGHT_BITS-1:0]                      up_tx,
    input  wire logic [WEIGHT_BITS-1:0]                      up_ty,
    input  wire bglt_pkg::qctl_t                             up_ctl,
    output logic                                             dn_valid,
    input  wire logic                                        dn_ready,
    output logic [bglt_pkg::NUM_BANKS-1:0][VALUE_BITS-1:0]   dn_rdata,
    output logic [WEIGHT_BITS-1:0]                           dn_tx,
    output logic [WEIGHT_BITS-1:0]                           dn_ty,
    output bglt_pkg::qctl_t                                  dn_ctl
);

    localparam int BANK_DEPTH = 2 ** ADDR_W;

    logic                       c_valid_reg;
    logic                       c_ready;
    logic                       load;
    logic [WEIGHT_BITS-1:0]     c_tx_reg;
    logic [WEIGHT_BITS-1:0]     c_ty_reg;
    bglt_pkg::qctl_t            c_ctl_reg;

    assign c_ready  = !c_valid_reg || dn_ready;
    assign up_ready = c_ready;
    assign load     = up_valid && c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            // Writes end here; only queries move on.
            c_valid_reg <= up_valid && up_query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            c_tx_reg  <= up_tx;
            c_ty_reg  <= up_ty;
            c_ctl_reg <= up_ctl;
        end
    end

    for (genvar b = 0; b < bglt_pkg::NUM_BANKS; b++)
    begin : g_bank
        logic [VALUE_BITS-1:0] mem [BANK_DEPTH];
        logic [VALUE_BITS-1:0] rdata_reg;

        always_ff @(posedge clk)
        begin
            if (load && up_we[b])
            begin
                mem[up_addr[b]] <= up_wdata;
            end
            if (load)
            begin
                rdata_reg <= mem[up_addr[b]];
            end
        end

        assign dn_rdata[b] = rdata_reg;
    end

    assign dn_valid = c_valid_reg;
    assign dn_tx    = c_tx_reg;
    assign dn_ty    = c_ty_reg;
    assign dn_ctl   = c_ctl_reg;

endmodule

`default_nettype wire

@@ rtl/core/bglt_lerp.sv @@
// Pipelined linear blend a + floor(w * (b - a) / 2^WEIGHT_BITS) over parallel lanes.
`default_nettype none

module bglt_lerp #(
    parameter int LANES       = 1,
    parameter int VALUE_BITS  = 24,
    parameter int WEIGHT_BITS = 16,
    parameter int SIDE_W      = 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              up_valid,
    output logic                                   up_ready,
    input  wire logic [LANES-1:0][VALUE_BITS-1:0]  up_a,
    input  wire logic [LANES-1:0][VALUE_BITS-1:0]  up_b,
    input  wire logic [WEIGHT_BITS-1:0]            up_w,
    input  wire logic [SIDE_W-1:0]                 up_side,
    output logic                                   dn_valid,
    input  wire logic                              dn_ready,
    output logic [LANES-1:0][VALUE_BITS-1:0]       dn_res,
    output logic [SIDE_W-1:0]                      dn_side
);

    localparam int DW = VALUE_BITS + 1;
    localparam int PW = VALUE_BITS + WEIGHT_BITS + 2;
    localparam int SW = VALUE_BITS + 2;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic r1;
    logic r2;
    logic r3;

    logic [LANES-1:0][VALUE_BITS-1:0]   a1_reg;
    logic [LANES-1:0][DW-1:0]           d1_reg;
    logic [WEIGHT_BITS-1:0]             w1_reg;
    logic [SIDE_W-1:0]                  side1_reg;

    logic [LANES-1:0][VALUE_BITS-1:0]   a2_reg;
    logic [LANES-1:0][PW-1:0]           p2_reg;
    logic [SIDE_W-1:0]                  side2_reg;

    logic [LANES-1:0][VALUE_BITS-1:0]   res3_reg;
    logic [SIDE_W-1:0]                  side3_reg;

    logic [LANES-1:0][DW-1:0]           d1_next;
    logic [LANES-1:0][PW-1:0]           p2_next;
    logic [LANES-1:0][VALUE_BITS-1:0]   res3_next;
    logic signed [PW-1:0]               shifted;
    logic [SW-1:0]                      sum;

    assign r3       = !v3_reg || dn_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign up_ready = r1;

    always_comb
    begin
        shifted = '0;
        sum     = '0;
        for (int l = 0; l < LANES; l++)
        begin
            d1_next[l] = {1'b0, up_b[l]} - {1'b0, up_a[l]};
            p2_next[l] = PW'($signed({1'b0, w1_reg}) * $signed(d1_reg[l]));
            // The exact result stays within the entry range, so the low bits
            // of the sum are the whole answer.
            shifted      = $signed(p2_reg[l]) >>> WEIGHT_BITS;
            sum          = shifted[SW-1:0] + {2'b00, a2_reg[l]};
            res3_next[l] = sum[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= up_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && up_valid)
        begin
            a1_reg    <= up_a;
            d1_reg    <= d1_next;
            w1_reg    <= up_w;
            side1_reg <= up_side;
        end
        if (r2 && v1_reg)
        begin
            a2_reg    <= a1_reg;
            p2_reg    <= p2_next;
            side2_reg <= side1_reg;
        end
        if (r3 && v2_reg)
        begin
            res3_reg  <= res3_next;
            side3_reg <= side2_reg;
        end
    end

    assign dn_valid = v3_reg;
    assign dn_res   = res3_reg;
    assign dn_side  = side3_reg;

endmodule

`default_nettype wire

@@ rtl/core/bilinear_grid_table_lookup.sv @@
// Top level of the bilinear grid table lookup.
`default_nettype none

// Holds a grid of unsigned values centered on the origin and answers each
// query with the bilinear blend of the four entries around a signed position.
// An item with cmd = write stores one entry and gives no result; an item with
// cmd = query gives exactly one result. One item is accepted per clock cycle
// unless in_stall is high. Two stages locate the cell, one reads the table,
// and two three-stage blend units (rows, then columns) do the weighting. The
// table sits in four banks split by column and row parity, so the four
// corners of a cell come out of a single read; writes use the same pipeline
// slot, so a query accepted right after a write sees the new entry. Entries
// never written since reset read as undefined.
// Configuration may be written only while no item is in flight.
module bilinear_grid_table_lookup #(
    parameter int HALF_COLS_MAX = 32,
    parameter int HALF_ROWS_MAX = 32,
    parameter int VALUE_BITS    = 24,
    parameter int WEIGHT_BITS   = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [bglt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [bglt_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   cmd,
    input  wire logic [bglt_pkg::IDX_W-1:0]             col,
    input  wire logic [bglt_pkg::IDX_W-1:0]             row,
    input  wire logic [bglt_pkg::ENTRY_W-1:0]           entry_value,
    input  wire logic signed [bglt_pkg::POS_W-1:0]      pos_x,
    input  wire logic signed [bglt_pkg::POS_W-1:0]      pos_y,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [bglt_pkg::ENTRY_W-1:0]                value,
    output logic                                        out_of_range
);

    localparam int ADDR_W = $clog2(HALF_COLS_MAX) + $clog2(HALF_ROWS_MAX);
    localparam int NB     = bglt_pkg::NUM_BANKS;
    localparam int OUT_W  = bglt_pkg::ENTRY_W;

    // Configuration registers.
    bglt_pkg::cfg_t     cfg_reg;
    bglt_pkg::cfg_reg_t cfg_sel;

    assign cfg_sel = bglt_pkg::cfg_reg_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_cols   <= bglt_pkg::HALF_W'(1);
            cfg_reg.half_rows   <= bglt_pkg::HALF_W'(1);
            cfg_reg.step_log2   <= '0;
            cfg_reg.table_ready <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                bglt_pkg::CFG_HALF_COLS:   cfg_reg.half_cols   <= cfg_data;
                bglt_pkg::CFG_HALF_ROWS:   cfg_reg.half_rows   <= cfg_data;
                bglt_pkg::CFG_STEP_LOG2:   cfg_reg.step_log2   <= cfg_data[bglt_pkg::STEP_W-1:0];
                bglt_pkg::CFG_TABLE_READY: cfg_reg.table_ready <= cfg_data[0];
            endcase
        end
    end

    // Locate -> store.
    logic                           loc_valid;
    logic                           loc_ready;
    logic                           loc_query;
    logic                           in_ready;
    logic [NB-1:0]                  loc_we;
    logic [NB-1:0][ADDR_W-1:0]      loc_addr;
    logic [VALUE_BITS-1:0]          loc_wdata;
    logic [WEIGHT_BITS-1:0]         loc_tx;
    logic [WEIGHT_BITS-1:0]         loc_ty;
    bglt_pkg::qctl_t                loc_ctl;

    // Store -> row blend.
    logic                           st_valid;
    logic                           st_ready;
    logic [NB-1:0][VALUE_BITS-1:0]  st_rdata;
    logic [WEIGHT_BITS-1:0]         st_tx;
    logic [WEIGHT_BITS-1:0]         st_ty;
    bglt_pkg::qctl_t                st_ctl;

    logic [1:0][VALUE_BITS-1:0]     row_a;
    logic [1:0][VALUE_BITS-1:0]     row_b;

    // Row blend -> column blend.
    logic                           rb_valid;
    logic                           rb_ready;
    logic [1:0][VALUE_BITS-1:0]     rb_res;
    logic [WEIGHT_BITS:0]           rb_side;

    logic [0:0][VALUE_BITS-1:0]     cb_res;
    logic [0:0]                     cb_side;

    assign in_stall = !in_ready;

    bglt_locate #(
        .HALF_COLS_MAX (HALF_COLS_MAX),
        .HALF_ROWS_MAX (HALF_ROWS_MAX),
        .VALUE_BITS    (VALUE_BITS),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) u_locate (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .up_valid    (in_valid),
        .up_ready    (in_ready),
        .cmd         (cmd),
        .col         (col),
        .row         (row),
        .entry_value (entry_value),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .dn_valid    (loc_valid),
        .dn_ready    (loc_ready),
        .dn_query    (loc_query),
        .dn_we       (loc_we),
        .dn_addr     (loc_addr),
        .dn_wdata    (loc_wdata),
        .dn_tx       (loc_tx),
        .dn_ty       (loc_ty),
        .dn_ctl      (loc_ctl)
    );

    bglt_store #(
        .VALUE_BITS  (VALUE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (loc_valid),
        .up_ready (loc_ready),
        .up_query (loc_query),
        .up_we    (loc_we),
        .up_addr  (loc_addr),
        .up_wdata (loc_wdata),
        .up_tx    (loc_tx),
        .up_ty    (loc_ty),
        .up_ctl   (loc_ctl),
        .dn_valid (st_valid),
        .dn_ready (st_ready),
        .dn_rdata (st_rdata),
        .dn_tx    (st_tx),
        .dn_ty    (st_ty),
        .dn_ctl   (st_ctl)
    );

    // Bank {row parity, column parity} holds the corner whose parities match.
    // A query that answers zero blends zeros, which gives zero exactly.
    always_comb
    begin
        row_a[0] = st_rdata[{st_ctl.row_odd, st_ctl.col_odd}];
        row_b[0] = st_rdata[{st_ctl.row_odd, !st_ctl.col_odd}];
        row_a[1] = st_rdata[{!st_ctl.row_odd, st_ctl.col_odd}];
        row_b[1] = st_rdata[{!st_ctl.row_odd, !st_ctl.col_odd}];
        if (st_ctl.zero)
        begin
            row_a = '0;
            row_b = '0;
        end
    end

    bglt_lerp #(
        .LANES       (2),
        .VALUE_BITS  (VALUE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .SIDE_W      (WEIGHT_BITS + 1)
    ) u_row_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (st_valid),
        .up_ready (st_ready),
        .up_a     (row_a),
        .up_b     (row_b),
        .up_w     (st_tx),
        .up_side  ({st_ty, st_ctl.oor}),
        .dn_valid (rb_valid),
        .dn_ready (rb_ready),
        .dn_res   (rb_res),
        .dn_side  (rb_side)
    );

    bglt_lerp #(
        .LANES       (1),
        .VALUE_BITS  (VALUE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .SIDE_W      (1)
    ) u_col_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (rb_valid),
        .up_ready (rb_ready),
        .up_a     (rb_res[0]),
        .up_b     (rb_res[1]),
        .up_w     (rb_side[WEIGHT_BITS:1]),
        .up_side  (rb_side[0]),
        .dn_valid (out_valid),
        .dn_ready (!out_stall),
        .dn_res   (cb_res),
        .dn_side  (cb_side)
    );

    assign value        = OUT_W'(cb_res[0]);
    assign out_of_range = cb_side[0];

endmodule

`default_nettype wire
